### rtl/smeu_pkg.sv
package smeu_pkg;

    localparam int unsigned STACK_DEPTH_DEF    = 64;
    localparam int unsigned VARIABLE_COUNT_DEF = 256;

    localparam int unsigned OPCODE_W = 5;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_PRINT = 5'd1, OP_STORE = 5'd2, OP_LOAD = 5'd3,
        OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
        OP_MOD = 5'd8, OP_JUMP = 5'd9, OP_JUMPIF = 5'd10, OP_JUMPIFNOT = 5'd11,
        OP_EQ = 5'd12, OP_NE = 5'd13, OP_GT = 5'd14, OP_LT = 5'd15,
        OP_GE = 5'd16, OP_LE = 5'd17, OP_END = 5'd18
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZERO = 3'd3,
        ST_BADVAR = 3'd4, ST_HALTED = 3'd5
    } t_status;

endpackage

### rtl/stack_machine_execute_unit.sv
// Sequence: each beat passes READ1, READ2, EXEC; print, store, jumps, end and any
// error then go to OUT; push and load via WRITE; other arithmetic and compares via
// MUL and WRITE; div and mod via the bit-serial divider (DIV), DIVFIN and WRITE.
// Throughput: one instruction at a time; the next beat is taken no earlier than the
// edge that takes the result.
// Reset: stack pointer, halt flag and control cleared; the variable store is
// cleared by a sweep after reset, with input held off.
module stack_machine_execute_unit #(
    parameter int unsigned STACK_DEPTH    = smeu_pkg::STACK_DEPTH_DEF,
    parameter int unsigned VARIABLE_COUNT = smeu_pkg::VARIABLE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [smeu_pkg::OPCODE_W-1:0] i_opcode,
    input  logic signed [smeu_pkg::WORD_W-1:0] i_operand,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [smeu_pkg::STATUS_W-1:0] o_status,
    output logic                         o_print_valid,
    output logic signed [smeu_pkg::WORD_W-1:0] o_print_value,
    output logic                         o_branch_taken,
    output logic signed [smeu_pkg::WORD_W-1:0] o_branch_label,
    output logic                         o_halted
);
    import smeu_pkg::*;

    localparam int unsigned SA_W = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned VA_W = $clog2(VARIABLE_COUNT);
    localparam int unsigned VC_W = $clog2(VARIABLE_COUNT + 1);
    localparam int unsigned DC_W = $clog2(WORD_W + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ1, S_READ2, S_EXEC, S_MUL, S_DIV, S_DIVFIN,
        S_WRITE, S_OUT
    } t_state;

    // storage
    logic [WORD_W-1:0] r_stack [STACK_DEPTH];
    logic [WORD_W-1:0] r_vars  [VARIABLE_COUNT];

    t_state             r_state;
    logic [SP_W-1:0]    r_sp;
    logic               r_halt;
    logic [VC_W-1:0]    r_clr;
    logic [OPCODE_W-1:0] r_op;
    logic [WORD_W-1:0]  r_arg;
    logic [WORD_W-1:0]  r_rhs, r_lhs, r_res;
    logic [WORD_W-1:0]  r_stk_q, r_var_q;
    logic [SA_W-1:0]    r_raddr;
    logic               r_var_ok;

    // divider
    logic [WORD_W-1:0]  r_quo, r_rem, r_dvs;
    logic [DC_W-1:0]    r_dcnt;
    logic               r_neg_q, r_neg_r;

    // output stage
    logic               r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic               r_pvalid, r_taken;
    logic [WORD_W-1:0]  r_pval, r_label;

    // stack and variable write ports
    logic               w_we;
    logic [SA_W-1:0]    w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic               v_we;
    logic [VA_W-1:0]    v_waddr;
    logic [WORD_W-1:0]  v_wdata;

    logic [WORD_W:0]    w_sub;
    logic [WORD_W-1:0]  w_remsh;
    logic               w_lt, w_gt;
    logic [WORD_W-1:0]  w_prod;

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_print_valid = r_pvalid;
    assign o_print_value = r_pval;
    assign o_branch_taken = r_taken;
    assign o_branch_label = r_label;
    assign o_halted = r_halt;

    assign w_lt = $signed(r_lhs) < $signed(r_rhs);
    assign w_gt = $signed(r_rhs) < $signed(r_lhs);
    assign w_prod = r_lhs * r_rhs;
    assign w_remsh = {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
    assign w_sub = {1'b0, w_remsh} - {1'b0, r_dvs};

    // memories
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        r_stk_q <= r_stack[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vars[v_waddr] <= v_wdata;
        end
        r_var_q <= r_vars[r_arg[VA_W-1:0]];
    end

    // write ports; store takes the top of stack held in r_rhs
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_raddr;
        w_wdata = r_res;
        v_we = 1'b0;
        v_waddr = r_arg[VA_W-1:0];
        v_wdata = r_rhs;
        if (r_state == S_CLEAR) begin
            v_we = 1'b1;
            v_waddr = r_clr[VA_W-1:0];
            v_wdata = '0;
        end else if (r_state == S_WRITE) begin
            w_we = 1'b1;
        end else if (r_state == S_EXEC && r_op == OP_STORE && !r_halt &&
                     r_sp != '0 && r_var_ok) begin
            v_we = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sp     <= '0;
            r_halt   <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VC_W'(VARIABLE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op     <= i_opcode;
                        r_arg    <= i_operand;
                        r_var_ok <= (i_operand < WORD_W'(VARIABLE_COUNT));
                        // top of stack address
                        r_raddr  <= SA_W'(r_sp - 1'b1);
                        r_state  <= S_READ1;
                    end
                end
                S_READ1: begin
                    // second from top
                    r_raddr <= SA_W'(r_sp - 2'd2);
                    r_state <= S_READ2;
                end
                S_READ2: begin
                    r_rhs   <= r_stk_q;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_lhs    <= r_stk_q;
                    r_status <= ST_OK;
                    r_pvalid <= 1'b0;
                    r_pval   <= '0;
                    r_taken  <= 1'b0;
                    r_label  <= '0;
                    r_state  <= S_OUT;
                    if (r_halt) begin
                        r_status <= ST_HALTED;
                    end else begin
                        case (r_op)
                            OP_PUSH: begin
                                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                    r_status <= ST_OVER;
                                end else begin
                                    r_raddr <= SA_W'(r_sp);
                                    r_res   <= r_arg;
                                    r_sp    <= r_sp + 1'b1;
                                    r_state <= S_WRITE;
                                end
                            end
                            OP_PRINT: begin
                                if (r_sp == '0) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    r_pvalid <= 1'b1;
                                    r_pval   <= r_rhs;
                                    r_sp     <= r_sp - 1'b1;
                                end
                            end
                            OP_STORE: begin
                                if (!r_var_ok) begin
                                    r_status <= ST_BADVAR;
                                end else if (r_sp == '0) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    r_sp <= r_sp - 1'b1;
                                end
                            end
                            OP_LOAD: begin
                                if (!r_var_ok) begin
                                    r_status <= ST_BADVAR;
                                end else if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                    r_status <= ST_OVER;
                                end else begin
                                    r_raddr <= SA_W'(r_sp);
                                    r_res   <= r_var_q;
                                    r_sp    <= r_sp + 1'b1;
                                    r_state <= S_WRITE;
                                end
                            end
                            OP_JUMP: begin
                                r_taken <= 1'b1;
                                r_label <= r_arg;
                            end
                            OP_JUMPIF, OP_JUMPIFNOT: begin
                                if (r_sp == '0) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    r_sp <= r_sp - 1'b1;
                                    if ((r_op == OP_JUMPIF && r_rhs == WORD_W'(1)) ||
                                        (r_op == OP_JUMPIFNOT && r_rhs == '0)) begin
                                        r_taken <= 1'b1;
                                        r_label <= r_arg;
                                    end
                                end
                            end
                            OP_END: begin
                                r_halt <= 1'b1;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                            OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
                                if (r_sp < SP_W'(2)) begin
                                    r_status <= ST_UNDER;
                                end else if ((r_op == OP_DIV || r_op == OP_MOD) &&
                                             r_rhs == '0) begin
                                    r_status <= ST_DIVZERO;
                                end else begin
                                    r_raddr <= SA_W'(r_sp - 2'd2);
                                    r_sp    <= r_sp - 1'b1;
                                    r_state <= S_MUL;
                                    if (r_op == OP_DIV || r_op == OP_MOD) begin
                                        // set up magnitudes for the divider
                                        r_quo   <= r_stk_q[WORD_W-1] ? -r_stk_q : r_stk_q;
                                        r_dvs   <= r_rhs[WORD_W-1] ? -r_rhs : r_rhs;
                                        r_rem   <= '0;
                                        r_dcnt  <= '0;
                                        r_neg_r <= r_stk_q[WORD_W-1];
                                        r_neg_q <= r_stk_q[WORD_W-1] ^ r_rhs[WORD_W-1];
                                        r_state <= S_DIV;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    // operands now registered in r_lhs/r_rhs
                    case (r_op)
                        OP_ADD:  r_res <= r_lhs + r_rhs;
                        OP_SUB:  r_res <= r_lhs - r_rhs;
                        OP_MUL:  r_res <= w_prod;
                        OP_EQ:   r_res <= WORD_W'(r_lhs == r_rhs);
                        OP_NE:   r_res <= WORD_W'(r_lhs != r_rhs);
                        OP_GT:   r_res <= WORD_W'(w_gt);
                        OP_LT:   r_res <= WORD_W'(w_lt);
                        OP_GE:   r_res <= WORD_W'(!w_lt);
                        OP_LE:   r_res <= WORD_W'(!w_gt);
                        default: r_res <= '0;
                    endcase
                    r_state <= S_WRITE;
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    if (!w_sub[WORD_W]) begin
                        r_rem <= w_sub[WORD_W-1:0];
                        r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_remsh;
                        r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DC_W'(WORD_W - 1)) begin
                        r_state <= S_DIVFIN;
                    end
                end
                S_DIVFIN: begin
                    if (r_op == OP_MOD) begin
                        r_res <= r_neg_r ? -r_rem : r_rem;
                    end else begin
                        r_res <= r_neg_q ? -r_quo : r_quo;
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
